// File: rtl/tsf_pkg.sv
// Shared types and constants for the timed service queue.
// No dependencies; every other file of the block refers to this package by scoped names.
package tsf_pkg;

   // Default ring depth and the cap on departures reported for one tick.
   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int RES_W         = $clog2(MAX_RESULTS);

   // Field widths.
   localparam int ID_W   = 16;
   localparam int TIME_W = 32;
   localparam int SVC_W  = 16;
   localparam int EV_W   = 2;
   localparam int OCC_W  = 5;

   // Input action codes.
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   // Result event codes.
   localparam logic [EV_W-1:0] EV_ACCEPT = 2'd0;
   localparam logic [EV_W-1:0] EV_FULL   = 2'd1;
   localparam logic [EV_W-1:0] EV_DEPART = 2'd2;

   // One queue entry as held in the ring memory.
   typedef struct packed {
      logic [ID_W-1:0]   customer_id;
      logic [TIME_W-1:0] arrival_time;
      logic [SVC_W-1:0]  service_time;
   } entry_type;

   // One result beat.
   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [ID_W-1:0]   departed_id;
      logic [TIME_W-1:0] wait_time;
      logic              next_valid;
      logic [ID_W-1:0]   next_id;
      logic [OCC_W-1:0]  occupancy;
      logic              last;
   } rsp_type;

endpackage

// File: rtl/tsf_channel_if.sv
// Valid/ready channel interfaces for the request and response sides of the queue.
// Depends on tsf_pkg for field widths.
interface tsf_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [tsf_pkg::ID_W-1:0]     customer_id;
   logic [tsf_pkg::TIME_W-1:0]   arrival_time;
   logic [tsf_pkg::SVC_W-1:0]    service_time;
   logic [tsf_pkg::TIME_W-1:0]   current_time;

   modport source (output valid, action, customer_id, arrival_time, service_time,
                   current_time, input ready);
   modport sink (input valid, action, customer_id, arrival_time, service_time,
                 current_time, output ready);
endinterface

interface tsf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tsf_pkg::EV_W-1:0]     event_res;
   logic [tsf_pkg::ID_W-1:0]     departed_id;
   logic [tsf_pkg::TIME_W-1:0]   wait_time;
   logic                         next_valid;
   logic [tsf_pkg::ID_W-1:0]     next_id;
   logic [tsf_pkg::OCC_W-1:0]    occupancy;
   logic                         last;

   modport source (output valid, event_res, departed_id, wait_time, next_valid, next_id,
                   occupancy, last, input ready);
   modport sink (input valid, event_res, departed_id, wait_time, next_valid, next_id,
                 occupancy, last, output ready);
endinterface

// File: rtl/tsf_store.sv
// Ring memory of queue entries: one write port, one read port, registered read data.
// Depends on tsf_pkg for the entry type.
module tsf_store #(
   parameter int  DEPTH = tsf_pkg::DEPTH_DEFAULT,
   localparam int PTR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PTR_W-1:0]    wr_addr,
   input  tsf_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [PTR_W-1:0]    rd_addr,
   output tsf_pkg::entry_type  rd_data
);

   tsf_pkg::entry_type mem_ff [DEPTH];
   tsf_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/timed_service_fifo_unit.sv
// Top level of the timed service queue: sequencer, head cache and result register.
// Depends on tsf_pkg, the channel interfaces in tsf_channel_if and the tsf_store memory.
//
//   Channel   Dir   Beat contents
//   req_bus   in    action, customer_id, arrival_time, service_time, current_time
//   rsp_bus   out   event_res, departed_id, wait_time, next_valid, next_id, occupancy, last
//
// An enqueue beat yields its result beat in the next cycle.
// A tick beat holds the request side while the head is tested and then while each departure
// is sent (at most 16 departures), paced by the single read port of the entry memory,
// which fetches the next head while one departs.
// A stalled response side holds the request side for longer still.
// Reset (synchronous) empties the queue; the entry memory itself is not cleared.
module timed_service_fifo_unit #(
   parameter int DEPTH = tsf_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tsf_req_if.sink     req_bus,
   tsf_rsp_if.source   rsp_bus
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RES_W = tsf_pkg::RES_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;

   // Advance a ring pointer, wrapping at DEPTH.
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   logic [1:0]                  state_ff, state_in;
   logic [PTR_W-1:0]            head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0]            tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [tsf_pkg::TIME_W-1:0]  finish_ff, finish_in;
   logic [tsf_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [RES_W-1:0]            dep_cnt_ff, dep_cnt_in;
   tsf_pkg::entry_type          head_ff, head_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tsf_pkg::rsp_type            out_ff, out_in;

   logic                        out_free;
   logic                        req_fire;
   logic                        is_full;
   logic                        finish_hit;
   logic [CNT_W-1:0]            count_dec;
   logic [tsf_pkg::TIME_W-1:0]  new_finish;
   logic                        emit;
   logic                        dep_last;
   logic                        wr_en;
   tsf_pkg::entry_type          wr_data;
   logic                        rd_en;
   logic [PTR_W-1:0]            rd_addr;
   tsf_pkg::entry_type          rd_data;

   // Entry memory.
   tsf_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ptr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshake and shared terms.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign is_full       = (count_ff == CNT_W'(DEPTH));
   assign finish_hit    = (count_ff != '0) && (finish_ff <= now_ff);
   assign count_dec     = count_ff - 1'b1;
   assign new_finish    = now_ff + tsf_pkg::TIME_W'(rd_data.service_time);
   assign emit          = (state_ff == ST_FETCH) && out_free;
   assign dep_last      = (dep_cnt_ff == RES_W'(tsf_pkg::MAX_RESULTS - 1)) ||
                          (count_dec == '0) || (new_finish > now_ff);

   // Enqueue write goes to the tail entry.
   assign wr_en   = req_fire && (req_bus.action == tsf_pkg::ACT_ENQUEUE) && !is_full;
   assign wr_data = '{customer_id:  req_bus.customer_id,
                      arrival_time: req_bus.arrival_time,
                      service_time: req_bus.service_time};

   // The read always fetches the entry behind the head as it will stand after this cycle.
   assign rd_addr = ring_next(head_ptr_in);

   // Sequencer and queue bookkeeping.
   always_comb begin
      state_in     = state_ff;
      head_ptr_in  = head_ptr_ff;
      tail_ptr_in  = tail_ptr_ff;
      count_in     = count_ff;
      finish_in    = finish_ff;
      now_in       = now_ff;
      dep_cnt_in   = dep_cnt_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_in       = out_ff;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.action == tsf_pkg::ACT_TICK) begin
                  now_in     = req_bus.current_time;
                  dep_cnt_in = '0;
                  state_in   = ST_CHECK;
               end else begin
                  if (!is_full) begin
                     tail_ptr_in = ring_next(tail_ptr_ff);
                     count_in    = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        finish_in = req_bus.current_time +
                                    tsf_pkg::TIME_W'(req_bus.service_time);
                        head_in   = wr_data;
                     end
                  end
                  rsp_valid_in = 1'b1;
                  out_in = '{event_res:   is_full ? tsf_pkg::EV_FULL : tsf_pkg::EV_ACCEPT,
                             departed_id: '0,
                             wait_time:   '0,
                             next_valid:  1'b0,
                             next_id:     '0,
                             occupancy:   tsf_pkg::OCC_W'(count_in),
                             last:        1'b1};
               end
            end
         end
         ST_CHECK: begin
            // Start fetching the following entry when the head has finished.
            if (finish_hit) begin
               rd_en    = 1'b1;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            // Retire the cached head; the fetched entry becomes the new head.
            if (emit) begin
               rsp_valid_in = 1'b1;
               out_in = '{event_res:   tsf_pkg::EV_DEPART,
                          departed_id: head_ff.customer_id,
                          wait_time:   now_ff - head_ff.arrival_time -
                                       tsf_pkg::TIME_W'(head_ff.service_time),
                          next_valid:  (count_dec != '0),
                          next_id:     (count_dec != '0) ? rd_data.customer_id : '0,
                          occupancy:   tsf_pkg::OCC_W'(count_dec),
                          last:        dep_last};
               head_ptr_in = ring_next(head_ptr_ff);
               count_in    = count_dec;
               head_in     = rd_data;
               dep_cnt_in  = dep_cnt_ff + 1'b1;
               if (count_dec != '0) begin
                  finish_in = new_finish;
               end
               if (dep_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         count_ff     <= '0;
         finish_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         count_ff     <= count_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      dep_cnt_ff <= dep_cnt_in;
      head_ff    <= head_in;
      out_ff     <= out_in;
   end

   // Response beat.
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.event_res   = out_ff.event_res;
   assign rsp_bus.departed_id = out_ff.departed_id;
   assign rsp_bus.wait_time   = out_ff.wait_time;
   assign rsp_bus.next_valid  = out_ff.next_valid;
   assign rsp_bus.next_id     = out_ff.next_id;
   assign rsp_bus.occupancy   = out_ff.occupancy;
   assign rsp_bus.last        = out_ff.last;

   // The entry count never passes the ring depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above ring depth");

   // An accepted enqueue into a queue that is not full adds exactly one entry.
   a_enqueue_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("enqueue did not add one entry");

   // Each departure removes one entry and leaves a beat on the response side.
   a_depart_count: assert property (@(posedge clock) disable iff (reset)
      emit |=> ((count_ff == $past(count_ff) - 1'b1) && rsp_bus.valid))
      else $error("departure bookkeeping mismatch");

endmodule

// File: bench/tb.sv
// Self-checking bench for the timed service queue: a directed opening, then random traffic.
// Depends on tsf_pkg, the channel interfaces in tsf_channel_if and timed_service_fifo_unit.
// The expected beats come from a model of the queue that runs on each accepted request.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH       = tsf_pkg::DEPTH_DEFAULT;
   localparam int ENQ_TARGET   = 260;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 150;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;

   // One request beat as the sender holds it.
   typedef struct packed {
      logic                       action;
      logic [tsf_pkg::ID_W-1:0]   customer_id;
      logic [tsf_pkg::TIME_W-1:0] arrival_time;
      logic [tsf_pkg::SVC_W-1:0]  service_time;
      logic [tsf_pkg::TIME_W-1:0] current_time;
   } request_type;

   // Patterns for the response side.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_EVERY_THIRD
   } ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsf_req_if req_if ();
   tsf_rsp_if rsp_if ();

   timed_service_fifo_unit #(.DEPTH(QDEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   request_type       queued_requests[$];
   tsf_pkg::rsp_type  due_outcomes[$];
   int                error_count = 0;
   int                beats_seen = 0;
   int                cycle_count = 0;
   logic              req_fire = 1'b0;

   // Shadow copy of the waiting line.
   logic [tsf_pkg::ID_W-1:0]   line_id[QDEPTH];
   logic [tsf_pkg::TIME_W-1:0] line_arr[QDEPTH];
   logic [tsf_pkg::SVC_W-1:0]  line_svc[QDEPTH];
   logic [tsf_pkg::TIME_W-1:0] line_finish = '0;
   int                         line_head = 0;
   int                         line_tail = 0;
   int                         line_count = 0;

   // Sender and receiver pacing state.
   int              burst_left = 0;
   int              gap_left = 0;
   int              hold_left = 0;
   logic            hold_done = 1'b0;
   int              mode_left = 0;
   int              pattern_phase = 0;
   ready_style_type ready_style = READY_ALWAYS;

   task automatic add_request(input logic act, input logic [31:0] id, input logic [31:0] arr,
                              input logic [31:0] svc, input logic [31:0] now);
      request_type r;
      r.action       = act;
      r.customer_id  = id[tsf_pkg::ID_W-1:0];
      r.arrival_time = arr;
      r.service_time = svc[tsf_pkg::SVC_W-1:0];
      r.current_time = now;
      queued_requests.push_back(r);
   endtask

   // Advances the shadow line by one accepted request and queues the beats it causes.
   task automatic service_line_step(input request_type r);
      tsf_pkg::rsp_type beat;
      int               n;
      beat = '0;
      n = 0;
      if (r.action == tsf_pkg::ACT_ENQUEUE) begin
         if (line_count >= QDEPTH) begin
            beat.event_res = tsf_pkg::EV_FULL;
         end else begin
            line_id[line_tail]  = r.customer_id;
            line_arr[line_tail] = r.arrival_time;
            line_svc[line_tail] = r.service_time;
            if (line_count == 0) begin
               line_finish = r.current_time + {16'd0, r.service_time};
            end
            line_tail = (line_tail + 1) % QDEPTH;
            line_count++;
            beat.event_res = tsf_pkg::EV_ACCEPT;
         end
         beat.occupancy = tsf_pkg::OCC_W'(line_count);
         beat.last = 1'b1;
         due_outcomes.push_back(beat);
      end else begin
         // Retire finished heads in order; each new head starts service now.
         while (n < tsf_pkg::MAX_RESULTS && line_count > 0 &&
                line_finish <= r.current_time) begin
            beat = '0;
            beat.event_res   = tsf_pkg::EV_DEPART;
            beat.departed_id = line_id[line_head];
            beat.wait_time   = r.current_time - line_arr[line_head]
                               - {16'd0, line_svc[line_head]};
            line_head = (line_head + 1) % QDEPTH;
            line_count--;
            if (line_count > 0) begin
               beat.next_valid = 1'b1;
               beat.next_id    = line_id[line_head];
               line_finish     = r.current_time + {16'd0, line_svc[line_head]};
            end
            beat.occupancy = tsf_pkg::OCC_W'(line_count);
            n++;
            beat.last = !(n < tsf_pkg::MAX_RESULTS && line_count > 0 &&
                          line_finish <= r.current_time);
            due_outcomes.push_back(beat);
         end
      end
   endtask

   // Sample both channels at the rising edge: check result beats, then model request beats.
   always @(posedge clock) begin
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         beats_seen++;
         if (due_outcomes.size() == 0) begin
            $error("result beat with nothing expected: event_res %0d id %h",
                   rsp_if.event_res, rsp_if.departed_id);
            error_count++;
         end else begin
            tsf_pkg::rsp_type exp_beat;
            exp_beat = due_outcomes.pop_front();
            if (rsp_if.event_res !== exp_beat.event_res) begin
               $error("event_res: expected %0d, got %0d", exp_beat.event_res, rsp_if.event_res);
               error_count++;
            end
            if (rsp_if.departed_id !== exp_beat.departed_id) begin
               $error("departed_id: expected %h, got %h", exp_beat.departed_id,
                      rsp_if.departed_id);
               error_count++;
            end
            if (rsp_if.wait_time !== exp_beat.wait_time) begin
               $error("wait_time: expected %h, got %h", exp_beat.wait_time, rsp_if.wait_time);
               error_count++;
            end
            if (rsp_if.next_valid !== exp_beat.next_valid) begin
               $error("next_valid: expected %b, got %b", exp_beat.next_valid,
                      rsp_if.next_valid);
               error_count++;
            end
            if (rsp_if.next_id !== exp_beat.next_id) begin
               $error("next_id: expected %h, got %h", exp_beat.next_id, rsp_if.next_id);
               error_count++;
            end
            if (rsp_if.occupancy !== exp_beat.occupancy) begin
               $error("occupancy: expected %0d, got %0d", exp_beat.occupancy,
                      rsp_if.occupancy);
               error_count++;
            end
            if (rsp_if.last !== exp_beat.last) begin
               $error("last: expected %b, got %b", exp_beat.last, rsp_if.last);
               error_count++;
            end
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         service_line_step({req_if.action, req_if.customer_id, req_if.arrival_time,
                            req_if.service_time, req_if.current_time});
      end
   end

   // Sender: offers beats in bursts of random length separated by random gaps.
   always @(negedge clock) begin : sender
      request_type r;
      logic        send_now;
      send_now = 1'b0;
      if (!reset && (!req_if.valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (queued_requests.size() > 0) begin
            send_now = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
         if (send_now) begin
            r = queued_requests.pop_front();
            req_if.action       <= r.action;
            req_if.customer_id  <= r.customer_id;
            req_if.arrival_time <= r.arrival_time;
            req_if.service_time <= r.service_time;
            req_if.current_time <= r.current_time;
         end
         req_if.valid <= send_now;
      end
   end

   // Receiver: one long hold-off once traffic is flowing, otherwise a changing stall pattern.
   always @(negedge clock) begin : receiver
      logic take;
      take = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
      end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end else begin
         if (mode_left == 0) begin
            ready_style = ready_style_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (ready_style)
            READY_ALWAYS: take = 1'b1;
            READY_MOSTLY: take = ($urandom_range(0, 9) < 7);
            READY_RARELY: take = ($urandom_range(0, 9) < 3);
            default: take = (pattern_phase % 3 == 0);
         endcase
         pattern_phase++;
      end
      rsp_if.ready <= take;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int          enq_count;
      int          pick;
      int          k;
      logic [31:0] now_t;

      req_if.valid        = 1'b0;
      req_if.action       = tsf_pkg::ACT_ENQUEUE;
      req_if.customer_id  = '0;
      req_if.arrival_time = '0;
      req_if.service_time = '0;
      req_if.current_time = '0;
      rsp_if.ready        = 1'b0;

      // Tick on an empty line gives no beat at all.
      add_request(tsf_pkg::ACT_TICK, 0, 0, 0, 0);
      // All-ones id, arrival and service fields; the finish time wraps past 2^32.
      add_request(tsf_pkg::ACT_ENQUEUE, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFF0);
      add_request(tsf_pkg::ACT_TICK, 0, 0, 0, 32'h0000_FFEE);
      add_request(tsf_pkg::ACT_TICK, 0, 0, 0, 32'h0000_FFEF);
      // Fill the ring; the last enqueue finds it full.
      for (k = 0; k <= QDEPTH; k++) begin
         add_request(tsf_pkg::ACT_ENQUEUE, k, 32'h100 - k, k, 32'h100);
      end
      add_request(tsf_pkg::ACT_TICK, 0, 0, 0, 32'h100);
      // A tick at the top of the time range drains everything that remains.
      add_request(tsf_pkg::ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF);
      add_request(tsf_pkg::ACT_ENQUEUE, 0, 0, 0, 0);
      add_request(tsf_pkg::ACT_TICK, 0, 0, 0, 0);

      // Random traffic: mostly a coherent timeline, with jumps, fill bursts and stray ticks.
      enq_count = 0;
      now_t = 32'd1000;
      while (enq_count < ENQ_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            for (k = 0; k < QDEPTH + 2; k++) begin
               add_request(tsf_pkg::ACT_ENQUEUE, $urandom, now_t - k, $urandom_range(0, 8),
                           now_t);
            end
            enq_count += QDEPTH + 2;
         end else if (pick < 8) begin
            now_t = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFC0 + $urandom_range(0, 60);
         end else if (pick < 55) begin
            add_request(tsf_pkg::ACT_ENQUEUE, $urandom,
                        ($urandom_range(0, 9) == 0) ? $urandom : now_t - $urandom_range(0, 50),
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30),
                        now_t);
            now_t = now_t + $urandom_range(0, 5);
            enq_count++;
         end else if (pick < 95) begin
            now_t = now_t + $urandom_range(0, 40);
            add_request(tsf_pkg::ACT_TICK, $urandom, $urandom, $urandom, now_t);
         end else begin
            add_request(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every expected beat to arrive.
      while (queued_requests.size() != 0 || req_if.valid) @(posedge clock);
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tsf_pkg.sv
rtl/tsf_channel_if.sv
rtl/tsf_store.sv
rtl/timed_service_fifo_unit.sv
bench/tb.sv
